// ----- rtl/core/lpt_pkg.sv -----
package lpt_pkg;

   // Table geometry
   localparam int TABLE_SIZE = 1024;
   localparam int IDX_W      = $clog2(TABLE_SIZE);
   localparam int CNT_W      = IDX_W + 1;

   // Fixed field widths of the channels
   localparam int HASH_W = 64;
   localparam int TURN_W = 15;
   localparam int GEN_W  = 16;
   localparam int SLOT_W = 11;

   // Slot index reported when no slot was filled or matched
   localparam logic [SLOT_W-1:0] SLOT_NONE = SLOT_W'(TABLE_SIZE);

   typedef enum logic [1:0] {
      KIND_INSERT  = 2'd0,
      KIND_LOOKUP  = 2'd1,
      KIND_NEW_GEN = 2'd2,
      KIND_UNUSED  = 2'd3
   } kind_type;

   // One table entry
   typedef struct packed {
      logic [GEN_W-1:0]  gen;
      logic [TURN_W-1:0] turn;
      logic [HASH_W-1:0] hash;
   } entry_type;

   // Controller to datapath
   typedef struct packed {
      logic clear_wr;   // write a zero entry at the sweep address
      logic capture;    // take in the request transaction
      logic load;       // read the home slot
      logic step;       // read the next slot
      logic insert_wr;  // fill the current slot
      logic finish;     // load the response register
      logic hit;        // response reports a slot
      logic new_gen;    // advance the generation tag
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      kind_type kind;
      logic     clear_last;
      logic     stale;
      logic     match;
      logic     last;
   } status_type;

endpackage

// ----- rtl/core/lpt_if.sv -----
interface lpt_req_if;
   import lpt_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [1:0]           kind;
   logic [HASH_W-1:0]    hash;
   logic [TURN_W-1:0]    turn;

   modport source (output valid, output kind, output hash, output turn, input ready);
   modport sink   (input valid, input kind, input hash, input turn, output ready);
endinterface

interface lpt_rsp_if;
   import lpt_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [SLOT_W-1:0]    slot_index;
   logic                 hit;
   logic [SLOT_W-1:0]    used_count;

   modport source (output valid, output slot_index, output hit, output used_count,
                   input ready);
   modport sink   (input valid, input slot_index, input hit, input used_count,
                   output ready);
endinterface

// ----- rtl/core/lpt_datapath.sv -----
module lpt_datapath
   import lpt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output status_type        status,
   input  logic [1:0]        req_kind,
   input  logic [HASH_W-1:0] req_hash,
   input  logic [TURN_W-1:0] req_turn,
   output logic [SLOT_W-1:0] rsp_slot_index,
   output logic              rsp_hit,
   output logic [SLOT_W-1:0] rsp_used_count
);

   // Slot storage
   entry_type mem [TABLE_SIZE];

   kind_type          kind_ff, kind_in;
   logic [HASH_W-1:0] hash_ff, hash_in;
   logic [TURN_W-1:0] turn_ff, turn_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [IDX_W-1:0]  count_ff, count_in;
   logic [GEN_W-1:0]  gen_ff, gen_in;
   logic [CNT_W-1:0]  used_ff, used_in;
   entry_type         rd_data_ff;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              hit_ff, hit_in;
   logic [SLOT_W-1:0] ucnt_ff, ucnt_in;

   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic              wr_en;
   entry_type         wr_data;

   // Read port: home slot on load, next slot on step
   assign rd_en   = cmd.load | cmd.step;
   assign rd_addr = cmd.load ? hash_ff[IDX_W-1:0] : idx_ff + IDX_W'(1);

   // Write port: sweep writes zeros, insert writes the new entry
   assign wr_en = cmd.clear_wr | cmd.insert_wr;
   always_comb begin
      if (cmd.clear_wr) begin
         wr_data = '0;
      end else begin
         wr_data.gen  = gen_ff;
         wr_data.turn = turn_ff;
         wr_data.hash = hash_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[idx_ff] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Next-state of the datapath registers
   always_comb begin
      kind_in  = kind_ff;
      hash_in  = hash_ff;
      turn_in  = turn_ff;
      idx_in   = idx_ff;
      count_in = count_ff;
      gen_in   = gen_ff;
      used_in  = used_ff;
      slot_in  = slot_ff;
      hit_in   = hit_ff;
      ucnt_in  = ucnt_ff;

      if (cmd.capture) begin
         kind_in = kind_type'(req_kind);
         hash_in = req_hash;
         turn_in = req_turn;
      end
      if (cmd.clear_wr || cmd.step) begin
         idx_in = idx_ff + IDX_W'(1);
      end
      if (cmd.load) begin
         idx_in   = hash_ff[IDX_W-1:0];
         count_in = '0;
      end
      if (cmd.step) begin
         count_in = count_ff + IDX_W'(1);
      end
      // used count saturates at the table size
      if (cmd.insert_wr && used_ff != CNT_W'(TABLE_SIZE)) begin
         used_in = used_ff + CNT_W'(1);
      end
      if (cmd.new_gen) begin
         gen_in  = gen_ff + GEN_W'(1);
         used_in = '0;
      end
      if (cmd.finish) begin
         slot_in = cmd.hit ? SLOT_W'(idx_ff) : SLOT_NONE;
         hit_in  = cmd.hit;
         ucnt_in = SLOT_W'(used_in);
      end
   end

   // Control-side registers
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= '0;
         gen_ff  <= GEN_W'(1);
         used_ff <= '0;
      end else begin
         idx_ff  <= idx_in;
         gen_ff  <= gen_in;
         used_ff <= used_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      hash_ff  <= hash_in;
      turn_ff  <= turn_in;
      count_ff <= count_in;
      slot_ff  <= slot_in;
      hit_ff   <= hit_in;
      ucnt_ff  <= ucnt_in;
   end

   // Status back to the controller
   assign status.kind       = kind_ff;
   assign status.clear_last = &idx_ff;
   assign status.stale      = rd_data_ff.gen != gen_ff;
   assign status.match      = (rd_data_ff.hash == hash_ff) && (rd_data_ff.turn == turn_ff);
   assign status.last       = &count_ff;

   assign rsp_slot_index = slot_ff;
   assign rsp_hit        = hit_ff;
   assign rsp_used_count = ucnt_ff;

endmodule

// ----- rtl/core/lpt_ctrl.sv -----
module lpt_ctrl
   import lpt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_LOAD  = 5'b00100,
      ST_CHECK = 5'b01000,
      ST_SPARE = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // Response register can take a new result this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (status.kind == KIND_INSERT || status.kind == KIND_LOOKUP) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end else if (out_free) begin
               // new generation or ignored kind: no probing
               cmd.finish  = 1'b1;
               cmd.new_gen = (status.kind == KIND_NEW_GEN);
               state_in    = ST_IDLE;
            end
         end
         ST_CHECK: begin
            if (status.kind == KIND_INSERT) begin
               if (status.stale) begin
                  if (out_free) begin
                     cmd.insert_wr = 1'b1;
                     cmd.finish    = 1'b1;
                     cmd.hit       = 1'b1;
                     state_in      = ST_IDLE;
                  end
               end else if (status.last) begin
                  if (out_free) begin
                     cmd.finish = 1'b1;
                     state_in   = ST_IDLE;
                  end
               end else begin
                  cmd.step = 1'b1;
               end
            end else begin
               // lookup: stale slot or last probe ends with a miss, match with a hit
               if (status.stale || status.last || status.match) begin
                  if (out_free) begin
                     cmd.finish = 1'b1;
                     cmd.hit    = !status.stale && status.match;
                     state_in   = ST_IDLE;
                  end
               end else begin
                  cmd.step = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Response valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- rtl/core/linear_probe_table_with_generation_unit.sv -----
// Sequence: an insert or lookup captures the request, reads the home slot, then
//   checks one slot per probe; new-generation and ignored requests do no probing.
// Throughput: one transaction at a time, one probe per cycle through the single read
//   port of the slot memory; a request is taken only while the unit is idle.
// Reset: synchronous; a clearing pass over TABLE_SIZE (1024) slots zeroes the slot tags,
//   with req ready low until it ends. Generation resets to one, used count to zero.
module linear_probe_table_with_generation_unit
   import lpt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   lpt_req_if.sink    req_ch,
   lpt_rsp_if.source  rsp_ch
);

   cmd_type    cmd;
   status_type status;

   lpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   lpt_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_kind       (req_ch.kind),
      .req_hash       (req_ch.hash),
      .req_turn       (req_ch.turn),
      .rsp_slot_index (rsp_ch.slot_index),
      .rsp_hit        (rsp_ch.hit),
      .rsp_used_count (rsp_ch.used_count)
   );

endmodule

// ----- rtl/core/lpt_checker.sv -----
module lpt_checker
   import lpt_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [SLOT_W-1:0] rsp_slot_index,
   input logic              rsp_hit,
   input logic [SLOT_W-1:0] rsp_used_count
);

   // A stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_slot_index)
         && $stable(rsp_hit) && $stable(rsp_used_count))
      else $error("response changed while stalled");

   // Hit and slot index agree
   a_hit_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hit == (rsp_slot_index != SLOT_NONE)))
      else $error("hit flag disagrees with slot index");

   // One transaction in work at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // Used count never passes the table size
   a_used_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_used_count <= SLOT_NONE)
      else $error("used count above table size");

endmodule

bind linear_probe_table_with_generation_unit lpt_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_slot_index (rsp_ch.slot_index),
   .rsp_hit        (rsp_ch.hit),
   .rsp_used_count (rsp_ch.used_count)
);
